// ===== hw/rtl/ssdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdf_pkg
// Codes and field widths for the servo status deframer.
// ----------------------------------------------------------------------------
package ssdf_pkg;

   // item kinds carried in req_tuser
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // final status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TIMEOUT   = 3'd1;
   localparam logic [2:0] ST_BAD_ID    = 3'd2;
   localparam logic [2:0] ST_BAD_LEN   = 3'd3;
   localparam logic [2:0] ST_CHECKSUM  = 3'd4;
   localparam logic [2:0] ST_ID_MISM   = 3'd5;
   localparam logic [2:0] ST_TOO_SMALL = 3'd6;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_HEADER  = 2'd1;
   localparam logic [1:0] CSR_MAX_ID  = 2'd2;

   localparam logic [31:0] WAIT_FOREVER = 32'hFFFF_FFFF;
   localparam logic [7:0]  MIN_LENGTH   = 8'd2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   // result payload, last field in the lowest bits
   typedef struct packed {
      logic [4:0] pad;
      logic [7:0] param_count;
      logic [7:0] servo_fault;
      logic [2:0] status;
      logic [7:0] param_byte;
      logic [7:0] param_index;
   } rsp_data_type;

endpackage

// ===== hw/rtl/servo_status_deframer.sv =====
// ----------------------------------------------------------------------------
// servo_status_deframer
// Parses a serial bus servo status packet and emits parameter bytes and at most
// one final status per armed reception.
// ----------------------------------------------------------------------------
// The result of an accepted transaction goes straight into the rsp_ output
// register. Throughput: one transaction per cycle unless a held result stalls
// req_tready; parser state and output register update together in one pass.
// Reset: synchronous, clears the parser to idle and loads the register
// defaults (timeout 1000 ticks, header 0xFF, largest unicast id 253).
module servo_status_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte, target_id, capacity
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // param_index, param_byte, status,
                                    // servo_fault, param_count, zero pad
   output logic        rsp_tuser,   // is_final
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_HUNT  = 3'd1;
   localparam logic [2:0] PH_ID    = 3'd2;
   localparam logic [2:0] PH_LEN   = 3'd3;
   localparam logic [2:0] PH_ERR   = 3'd4;
   localparam logic [2:0] PH_PARAM = 3'd5;
   localparam logic [2:0] PH_CSUM  = 3'd6;

   logic [31:0] timeout_ff;
   logic [7:0]  header_ff;
   logic [7:0]  max_id_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  hdr_seen_ff, hdr_seen_in;
   logic [7:0]  want_id_ff, want_id_in;
   logic [7:0]  room_ff, room_in;
   logic [7:0]  rx_id_ff, rx_id_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  err_ff, err_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  index_ff, index_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic        ovf_ff, ovf_in;

   logic                  rsp_valid_ff;
   logic                  rsp_final_ff;
   ssdf_pkg::rsp_data_type rsp_data_ff;

   logic                  accept;
   logic                  emit;
   logic                  emit_final;
   ssdf_pkg::rsp_data_type res;

   logic [1:0]  kind;
   logic [7:0]  rx_byte;
   logic [7:0]  exp_id;
   logic [7:0]  cap;
   logic [31:0] elapsed_inc;
   logic        timeout_on;
   logic [7:0]  timeout_count;
   logic [7:0]  index_inc;

   assign kind    = req_tuser;
   assign rx_byte = req_tdata[7:0];
   assign exp_id  = req_tdata[15:8];
   assign cap     = req_tdata[23:16];

   // accept a new transaction only when the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_final_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign timeout_on    = (timeout_ff != ssdf_pkg::WAIT_FOREVER);
   assign timeout_count = (phase_ff >= PH_ERR) ? count_ff : 8'd0;
   assign elapsed_inc   = (elapsed_ff != 32'hFFFF_FFFF) ? elapsed_ff + 32'd1 : elapsed_ff;
   assign index_inc     = index_ff + 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      hdr_seen_in = hdr_seen_ff;
      want_id_in  = want_id_ff;
      room_in     = room_ff;
      rx_id_in    = rx_id_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      sum_in      = sum_ff;
      index_in    = index_ff;
      elapsed_in  = elapsed_ff;
      ovf_in      = ovf_ff;
      emit        = 1'b0;
      emit_final  = 1'b0;
      res         = '0;

      if (kind == ssdf_pkg::KIND_START) begin
         if (exp_id > max_id_ff) begin
            emit       = 1'b1;
            emit_final = 1'b1;
            res.status = ssdf_pkg::ST_BAD_ID;
            phase_in   = PH_IDLE;
         end else begin
            phase_in    = PH_HUNT;
            hdr_seen_in = 2'd0;
            want_id_in  = exp_id;
            room_in     = cap;
            rx_id_in    = 8'd0;
            count_in    = 8'd0;
            err_in      = 8'd0;
            sum_in      = 8'd0;
            index_in    = 8'd0;
            elapsed_in  = 32'd0;
            ovf_in      = 1'b0;
         end
      end else if (phase_ff != PH_IDLE && kind == ssdf_pkg::KIND_TICK) begin
         elapsed_in = elapsed_inc;
         if (timeout_on && elapsed_inc >= timeout_ff) begin
            emit            = 1'b1;
            emit_final      = 1'b1;
            res.status      = ssdf_pkg::ST_TIMEOUT;
            res.param_count = timeout_count;
            phase_in        = PH_IDLE;
         end
      end else if (phase_ff != PH_IDLE && kind == ssdf_pkg::KIND_BYTE) begin
         if (timeout_on && elapsed_ff >= timeout_ff) begin
            // drop the byte, the reception has run out of time
            emit            = 1'b1;
            emit_final      = 1'b1;
            res.status      = ssdf_pkg::ST_TIMEOUT;
            res.param_count = timeout_count;
            phase_in        = PH_IDLE;
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (rx_byte == header_ff) begin
                     hdr_seen_in = hdr_seen_ff + 2'd1;
                     if (hdr_seen_ff != 2'd0) begin
                        phase_in = PH_ID;
                     end
                  end else begin
                     hdr_seen_in = 2'd0;
                  end
               end
               PH_ID: begin
                  if (rx_byte != header_ff) begin
                     if (rx_byte > max_id_ff) begin
                        emit       = 1'b1;
                        emit_final = 1'b1;
                        res.status = ssdf_pkg::ST_BAD_ID;
                        phase_in   = PH_IDLE;
                     end else begin
                        rx_id_in = rx_byte;
                        sum_in   = rx_byte;
                        phase_in = PH_LEN;
                     end
                  end
               end
               PH_LEN: begin
                  if (rx_byte < ssdf_pkg::MIN_LENGTH) begin
                     emit       = 1'b1;
                     emit_final = 1'b1;
                     res.status = ssdf_pkg::ST_BAD_LEN;
                     phase_in   = PH_IDLE;
                  end else begin
                     count_in = rx_byte - ssdf_pkg::MIN_LENGTH;
                     ovf_in   = (rx_byte - ssdf_pkg::MIN_LENGTH) > room_ff;
                     sum_in   = sum_ff + rx_byte;
                     phase_in = PH_ERR;
                  end
               end
               PH_ERR: begin
                  err_in   = rx_byte;
                  sum_in   = sum_ff + rx_byte;
                  index_in = 8'd0;
                  phase_in = (count_ff != 8'd0) ? PH_PARAM : PH_CSUM;
               end
               PH_PARAM: begin
                  sum_in   = sum_ff + rx_byte;
                  index_in = index_inc;
                  if (index_ff < room_ff) begin
                     emit            = 1'b1;
                     res.param_index = index_ff;
                     res.param_byte  = rx_byte;
                     res.param_count = count_ff;
                  end
                  if (index_inc >= count_ff) begin
                     phase_in = PH_CSUM;
                  end
               end
               PH_CSUM: begin
                  emit            = 1'b1;
                  emit_final      = 1'b1;
                  res.param_count = count_ff;
                  phase_in        = PH_IDLE;
                  priority if (rx_byte != ~sum_ff) begin
                     res.status = ssdf_pkg::ST_CHECKSUM;
                  end else if (rx_id_ff != want_id_ff) begin
                     res.status = ssdf_pkg::ST_ID_MISM;
                  end else begin
                     res.status      = ovf_ff ? ssdf_pkg::ST_TOO_SMALL : ssdf_pkg::ST_OK;
                     res.servo_fault = err_ff;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 32'd1000;
         header_ff  <= 8'd255;
         max_id_ff  <= 8'd253;
      end else if (csr_we) begin
         unique case (csr_index)
            ssdf_pkg::CSR_TIMEOUT: timeout_ff <= csr_wdata;
            ssdf_pkg::CSR_HEADER:  header_ff  <= csr_wdata[7:0];
            ssdf_pkg::CSR_MAX_ID:  max_id_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hdr_seen_ff <= 2'd0;
         want_id_ff  <= 8'd0;
         room_ff     <= 8'd0;
         rx_id_ff    <= 8'd0;
         count_ff    <= 8'd0;
         err_ff      <= 8'd0;
         sum_ff      <= 8'd0;
         index_ff    <= 8'd0;
         elapsed_ff  <= 32'd0;
         ovf_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hdr_seen_ff <= hdr_seen_in;
         want_id_ff  <= want_id_in;
         room_ff     <= room_in;
         rx_id_ff    <= rx_id_in;
         count_ff    <= count_in;
         err_ff      <= err_in;
         sum_ff      <= sum_in;
         index_ff    <= index_in;
         elapsed_ff  <= elapsed_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload needs no reset, load only with a new result
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_final_ff <= emit_final;
         rsp_data_ff  <= res;
      end
   end

endmodule

// ===== sim/servo_status_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// servo_status_deframer_tb
// Drives start, byte and tick transactions into the status packet deframer,
// from short directed packets and then random receptions under several
// register settings. A parser model in the testbench predicts every parameter
// byte and final status, and the returned results are checked field by field.
// ----------------------------------------------------------------------------
module servo_status_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int unsigned CLK_PERIOD = 8;
   localparam int unsigned RESET_CYCLES = 7;
   localparam int unsigned PHASE_ITEMS = 15;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned HOLD_AFTER_REPLIES = 25;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES = 10;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned MAX_REPORTS = 10;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HUNT, PH_ID, PH_LEN, PH_ERR, PH_PARAM, PH_CSUM
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] data;
   } bus_item_type;

   typedef struct packed {
      logic       is_final;
      logic [7:0] param_count;
      logic [7:0] servo_fault;
      logic [2:0] status;
      logic [7:0] param_byte;
      logic [7:0] param_index;
   } status_reply_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ssdf_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // data_byte, target_id, capacity
   logic [1:0]                      req_tuser = '0;   // kind
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ssdf_pkg::RSP_DATA_W-1:0] rsp_tdata;        // param_index, param_byte, status,
                                                      // servo_fault, param_count, pad
   logic                            rsp_tuser;        // is_final
   logic                            csr_we = 1'b0;
   logic [1:0]                      csr_index = '0;
   logic [31:0]                     csr_wdata = '0;

   // register copies, at their reset values
   logic [31:0] cfg_timeout = 32'd1000;
   logic [7:0]  cfg_header = 8'hFF;
   logic [7:0]  cfg_max_id = 8'd253;

   // parser state
   parse_phase_type rx_phase = PH_IDLE;
   logic [1:0]      hdr_run = '0;
   logic [7:0]      want_id = '0;
   logic [7:0]      room = '0;
   logic [7:0]      got_id = '0;
   logic [7:0]      plen = '0;
   logic [7:0]      err_byte = '0;
   logic [7:0]      csum = '0;
   logic [7:0]      pidx = '0;
   logic [31:0]     ticks_seen = '0;
   logic            overflow = 1'b0;

   bus_item_type     pending_items[$];
   status_reply_type expected_replies[$];
   bus_item_type     next_item;

   int unsigned queued_count = 0;
   int unsigned idle_pct = 0;
   int unsigned tick_pct = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned hold_left = 0;
   bit          long_hold_done = 1'b0;
   int unsigned replies_seen = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   servo_status_deframer i_dut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tuser,
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------------
   function automatic logic rx_expired();
      return cfg_timeout != ssdf_pkg::WAIT_FOREVER && ticks_seen >= cfg_timeout;
   endfunction

   task automatic post_final(input logic [2:0] st, input logic [7:0] derr,
                             input logic [7:0] cnt);
      status_reply_type r;
      r = '0;
      r.is_final = 1'b1;
      r.status = st;
      r.servo_fault = derr;
      r.param_count = cnt;
      expected_replies.push_back(r);
      rx_phase = PH_IDLE;
   endtask

   task automatic parse_status_item(input logic [1:0] kind, input logic [23:0] data);
      logic [7:0]       b;
      logic [7:0]       eid;
      status_reply_type r;
      b = data[7:0];
      eid = data[15:8];
      if (kind == ssdf_pkg::KIND_START) begin
         if (eid > cfg_max_id) begin
            post_final(ssdf_pkg::ST_BAD_ID, 8'd0, 8'd0);
         end else begin
            rx_phase = PH_HUNT;
            hdr_run = '0;
            want_id = eid;
            room = data[23:16];
            got_id = '0;
            plen = '0;
            err_byte = '0;
            csum = '0;
            pidx = '0;
            ticks_seen = '0;
            overflow = 1'b0;
         end
      end else if (rx_phase != PH_IDLE && kind != KIND_UNUSED) begin
         if (kind == ssdf_pkg::KIND_TICK) begin
            if (ticks_seen != ssdf_pkg::WAIT_FOREVER) ticks_seen++;
            if (rx_expired())
               post_final(ssdf_pkg::ST_TIMEOUT, 8'd0, (rx_phase >= PH_ERR) ? plen : 8'd0);
         end else if (rx_expired()) begin
            // drop the byte, the reception has run out of time
            post_final(ssdf_pkg::ST_TIMEOUT, 8'd0, (rx_phase >= PH_ERR) ? plen : 8'd0);
         end else begin
            case (rx_phase)
               PH_HUNT: begin
                  if (b == cfg_header) begin
                     hdr_run++;
                     if (hdr_run >= 2'd2) rx_phase = PH_ID;
                  end else begin
                     hdr_run = '0;
                  end
               end
               PH_ID: begin
                  // further header bytes are skipped
                  if (b != cfg_header) begin
                     if (b > cfg_max_id) begin
                        post_final(ssdf_pkg::ST_BAD_ID, 8'd0, 8'd0);
                     end else begin
                        got_id = b;
                        csum = b;
                        rx_phase = PH_LEN;
                     end
                  end
               end
               PH_LEN: begin
                  if (b < ssdf_pkg::MIN_LENGTH) begin
                     post_final(ssdf_pkg::ST_BAD_LEN, 8'd0, 8'd0);
                  end else begin
                     plen = b - ssdf_pkg::MIN_LENGTH;
                     overflow = plen > room;
                     csum = csum + b;
                     rx_phase = PH_ERR;
                  end
               end
               PH_ERR: begin
                  err_byte = b;
                  csum = csum + b;
                  pidx = '0;
                  rx_phase = (plen != 8'd0) ? PH_PARAM : PH_CSUM;
               end
               PH_PARAM: begin
                  csum = csum + b;
                  if (pidx < room) begin
                     r = '0;
                     r.param_index = pidx;
                     r.param_byte = b;
                     r.param_count = plen;
                     expected_replies.push_back(r);
                  end
                  pidx++;
                  if (pidx >= plen) rx_phase = PH_CSUM;
               end
               PH_CSUM: begin
                  if (b != ~csum)
                     post_final(ssdf_pkg::ST_CHECKSUM, 8'd0, plen);
                  else if (got_id != want_id)
                     post_final(ssdf_pkg::ST_ID_MISM, 8'd0, plen);
                  else
                     post_final(overflow ? ssdf_pkg::ST_TOO_SMALL : ssdf_pkg::ST_OK,
                                err_byte, plen);
               end
               default: rx_phase = PH_IDLE;
            endcase
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_item(input logic [1:0] kind, input logic [7:0] b,
                             input logic [7:0] eid, input logic [7:0] cap);
      bus_item_type it;
      it.kind = kind;
      it.data = {cap, eid, b};
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic queue_tick();
      queue_item(ssdf_pkg::KIND_TICK, rand_byte(), rand_byte(), rand_byte());
   endtask

   task automatic queue_rx_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < tick_pct) queue_tick();
      queue_item(ssdf_pkg::KIND_BYTE, b, rand_byte(), rand_byte());
   endtask

   // one armed reception, mostly well formed, sometimes broken on purpose
   task automatic queue_reception(input int unsigned n, input logic [7:0] cap);
      logic [7:0]  eid;
      logic [7:0]  rid;
      logic [7:0]  len;
      logic [7:0]  sum;
      logic [7:0]  pb;
      logic [7:0]  chk;
      int unsigned fault;
      fault = $urandom_range(0, 99);
      eid = ($urandom_range(0, 99) < 5) ? rand_byte() : 8'($urandom_range(0, cfg_max_id));
      queue_item(ssdf_pkg::KIND_START, rand_byte(), eid, cap);
      repeat ($urandom_range(0, 2)) queue_rx_byte(rand_byte());
      repeat ($urandom_range(2, 4)) queue_rx_byte(cfg_header);
      rid = (fault < 8) ? rand_byte() : eid;
      queue_rx_byte(rid);
      if (fault >= 8 && fault < 13) begin
         queue_rx_byte(8'($urandom_range(0, 1)));
         return;
      end
      len = 8'(n) + ssdf_pkg::MIN_LENGTH;
      queue_rx_byte(len);
      sum = rid + len;
      pb = rand_byte();
      queue_rx_byte(pb);
      sum = sum + pb;
      repeat (n) begin
         pb = rand_byte();
         queue_rx_byte(pb);
         sum = sum + pb;
      end
      // leave it unfinished, the next start drops it
      if (fault >= 13 && fault < 18) return;
      chk = ~sum;
      if (fault >= 18 && fault < 25) chk = chk ^ 8'($urandom_range(1, 255));
      queue_rx_byte(chk);
      if (fault >= 95) repeat ($urandom_range(1, 3)) queue_rx_byte(rand_byte());
   endtask

   task automatic queue_random_receptions(input int unsigned count);
      int unsigned target;
      target = queued_count + count;
      while (queued_count < target) begin
         if ($urandom_range(0, 99) < 3)
            queue_item(KIND_UNUSED, rand_byte(), rand_byte(), rand_byte());
         queue_reception(($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 6),
                         ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 253))
                                                     : 8'($urandom_range(0, 8)));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ssdf_pkg::CSR_TIMEOUT: cfg_timeout = val;
         ssdf_pkg::CSR_HEADER:  cfg_header = val[7:0];
         ssdf_pkg::CSR_MAX_ID:  cfg_max_id = val[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [31:0] tmo, input logic [7:0] hdr,
                            input logic [7:0] max_id, input int unsigned idle,
                            input int unsigned ticks, input bit with_long);
      wait_drained();
      // idle before the register writes, with no transaction sent
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(ssdf_pkg::CSR_TIMEOUT, tmo);
      write_csr(ssdf_pkg::CSR_HEADER, {24'd0, hdr});
      write_csr(ssdf_pkg::CSR_MAX_ID, {24'd0, max_id});
      @(negedge clock);
      idle_pct = idle;
      tick_pct = ticks;
      if (with_long) queue_reception(253, 8'd253);
      queue_random_receptions(PHASE_ITEMS);
   endtask

   initial begin
      // directed: ignored input, bad start ids, dropped reception, overflow, empty
      queue_item(ssdf_pkg::KIND_BYTE, 8'h5A, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00);
      queue_item(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      queue_item(ssdf_pkg::KIND_START, 8'h00, 8'd254, 8'd10);
      queue_item(ssdf_pkg::KIND_START, 8'hFF, 8'd255, 8'd10);
      queue_item(ssdf_pkg::KIND_START, 8'h00, 8'd7, 8'd9);
      queue_item(ssdf_pkg::KIND_BYTE, 8'hFF, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_START, 8'h00, 8'd1, 8'd1);
      queue_item(ssdf_pkg::KIND_BYTE, 8'hFF, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_BYTE, 8'hFF, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_BYTE, 8'hFF, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_BYTE, 8'h01, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_BYTE, 8'h04, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_BYTE, 8'h80, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_BYTE, 8'hAA, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_BYTE, 8'h55, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_BYTE, 8'h7B, 8'h00, 8'h00);
      queue_item(ssdf_pkg::KIND_START, 8'h00, 8'd0, 8'd253);
      queue_item(ssdf_pkg::KIND_BYTE, 8'hFF, 8'hFF, 8'hFF);
      queue_item(ssdf_pkg::KIND_BYTE, 8'hFF, 8'hFF, 8'hFF);
      queue_item(ssdf_pkg::KIND_BYTE, 8'h00, 8'hFF, 8'hFF);
      queue_item(ssdf_pkg::KIND_BYTE, 8'h02, 8'hFF, 8'hFF);
      queue_item(ssdf_pkg::KIND_BYTE, 8'h00, 8'hFF, 8'hFF);
      queue_item(ssdf_pkg::KIND_BYTE, 8'hFD, 8'hFF, 8'hFF);

      tick_pct = 3;
      idle_pct = 30;
      queue_random_receptions(PHASE_ITEMS);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_phase(32'd1, 8'h00, 8'd254, 20, 3, 1'b0);
      run_phase(ssdf_pkg::WAIT_FOREVER, 8'hA5, 8'd0, 40, 5, 1'b1);
      run_phase(32'd6, 8'hFF, 8'd100, 0, 10, 1'b0);
      run_phase(32'd20, rand_byte(), 8'($urandom_range(0, 254)), 15, 8, 1'b0);
      // closing stretch runs flat out on both sides
      run_phase(32'd3, 8'h7E, 8'd253, 0, 4, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_replies.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) parse_status_item(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               next_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_item.kind;
               req_tdata <= next_item.data;
               if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   task automatic check_reply();
      ssdf_pkg::rsp_data_type got;
      status_reply_type       want;
      got = ssdf_pkg::rsp_data_type'(rsp_tdata);
      if (expected_replies.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, final=%0b tdata=%h", $time, rsp_tuser,
                     rsp_tdata);
      end else begin
         want = expected_replies.pop_front();
         if (rsp_tuser !== want.is_final || got.param_index !== want.param_index ||
             got.param_byte !== want.param_byte || got.status !== want.status ||
             got.servo_fault !== want.servo_fault ||
             got.param_count !== want.param_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $write("%0t: result mismatch, expected final=%0b idx=%0d byte=%h",
                      $time, want.is_final, want.param_index, want.param_byte);
               $write(" status=%0d err=%h count=%0d,",
                      want.status, want.servo_fault, want.param_count);
               $display(" got final=%0b idx=%0d byte=%h status=%0d err=%h count=%0d",
                        rsp_tuser, got.param_index, got.param_byte, got.status,
                        got.servo_fault, got.param_count);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_reply();
            replies_seen++;
         end
         // hold off once for a long stretch so the block backs up
         if (!long_hold_done && replies_seen >= HOLD_AFTER_REPLIES) begin
            hold_left = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct) recv_gap = $urandom_range(1, 13);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: cycles without a transaction on either side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== servo_status_deframer.f =====
hw/rtl/ssdf_pkg.sv
hw/rtl/servo_status_deframer.sv
sim/servo_status_deframer_tb.sv
